// ----- sv/lzw_variable_width_decoder_macros.svh -----
// Assertion macros for the LZW variable width decoder checker.
// Depends on nothing; included by the checker file.
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LZWVD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LZWVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lzwvd_pkg.sv -----
// Shared types and constants of the LZW variable width decoder.
// Depends on nothing; used by every module of the block.
`default_nettype none
package lzwvd_pkg;

   // request kinds
   localparam logic [1:0] OP_FEED  = 2'd0;
   localparam logic [1:0] OP_PULL  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // response status codes
   localparam logic [2:0] ST_BYTE    = 3'd0;
   localparam logic [2:0] ST_NEED    = 3'd1;
   localparam logic [2:0] ST_TAKEN   = 3'd2;
   localparam logic [2:0] ST_REFUSED = 3'd3;
   localparam logic [2:0] ST_ENDED   = 3'd4;
   localparam logic [2:0] ST_ERROR   = 3'd5;

   // decoder phases
   localparam logic [2:0] PH_RUN     = 3'd0;
   localparam logic [2:0] PH_FIRST   = 3'd1;
   localparam logic [2:0] PH_LITERAL = 3'd2;
   localparam logic [2:0] PH_ENDED   = 3'd3;
   localparam logic [2:0] PH_ERROR   = 3'd4;

   localparam logic [11:0] CODE_CLEAR   = 12'h100;
   localparam logic [11:0] CODE_EOI     = 12'h101;
   localparam logic [11:0] FREE_START   = 12'd257;
   localparam logic [11:0] FREE_RESTART = 12'd258;
   localparam logic [11:0] FREE_MAX     = 12'd4095;
   localparam logic [11:0] LITERAL_MAX  = 12'd255;
   localparam logic [5:0]  FEED_MAX_CNT = 6'd24;
   localparam logic [3:0]  WIDTH_MIN    = 4'd9;
   localparam logic [3:0]  WIDTH_MAX    = 4'd11;
   localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;

   localparam int STACK_IDX_W = 13;

   typedef struct packed {
      logic        we;
      logic [11:0] waddr;
      logic [11:0] wprefix;
      logic [7:0]  wsuffix;
      logic [11:0] raddr;
   } dict_cmd_type;

   typedef struct packed {
      logic                   we;
      logic [STACK_IDX_W-1:0] waddr;
      logic [7:0]             wdata;
      logic [STACK_IDX_W-1:0] raddr;
   } stack_cmd_type;

endpackage
`default_nettype wire

// ----- sv/lzwvd_dict.sv -----
// Dictionary memory: prefix and suffix per code, one write and one read port.
// Depends on lzwvd_pkg; read data is registered.
`default_nettype none
module lzwvd_dict #(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic                  clock,
   input  wire lzwvd_pkg::dict_cmd_type cmd,
   output logic [11:0]                rd_prefix,
   output logic [7:0]                 rd_suffix
);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [11:0] prefix_mem [TABLE_DEPTH];
   logic [7:0]  suffix_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         prefix_mem[cmd.waddr[AW-1:0]] <= cmd.wprefix;
         suffix_mem[cmd.waddr[AW-1:0]] <= cmd.wsuffix;
      end
      rd_prefix <= prefix_mem[cmd.raddr[AW-1:0]];
      rd_suffix <= suffix_mem[cmd.raddr[AW-1:0]];
   end
endmodule
`default_nettype wire

// ----- sv/lzwvd_stack.sv -----
// Reversal stack memory for decoded strings, one write and one read port.
// Depends on lzwvd_pkg; read data is registered.
`default_nettype none
module lzwvd_stack #(
   parameter int STACK_DEPTH = 4096
) (
   input  wire logic                   clock,
   input  wire lzwvd_pkg::stack_cmd_type cmd,
   output logic [7:0]                  rd_data
);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0] stack_mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         stack_mem[cmd.waddr[AW-1:0]] <= cmd.wdata;
      end
      rd_data <= stack_mem[cmd.raddr[AW-1:0]];
   end
endmodule
`default_nettype wire

// ----- sv/lzw_variable_width_decoder.sv -----
// Top level of the LZW variable width decoder: control sequencer and registers.
// Depends on lzwvd_pkg, lzwvd_dict and lzwvd_stack.
//
//   channel  dir  ports          payload
//   req      in   req_t*         tdata: in_byte   tuser: opcode
//   rsp      out  rsp_t*         tdata: out_byte  tuser: status
//   csr      in   csr_we/wdata   output_limit
//
// One request at a time. Feed, start, refused, ended and error go from accept to
// the emit state; a pop passes pop-data, a literal, need-input or end code the loop;
// a pull that decodes a code passes the loop, a walk and walk-data pair per chain
// step, then walk, finish and emit, plus a loop pass per first or clear code.
// Reset is synchronous; no clearing pass, the memories hold stale data.
// A waiting response holds the emit state; req_tready rises once it is loaded.
`default_nettype none
module lzw_variable_width_decoder #(
   parameter int TABLE_DEPTH = 2048,
   parameter int STACK_DEPTH = 4096,
   parameter int CHAIN_LIMIT = 4000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   localparam int SLW = $clog2(STACK_DEPTH + 1);
   localparam int CLW = $clog2(CHAIN_LIMIT + 1);
   localparam int SIW = lzwvd_pkg::STACK_IDX_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOP   = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_WALKDT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_POPDT  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [31:0]    buf_ff, buf_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [3:0]     width_ff, width_in;
   logic [11:0]    nfc_ff, nfc_in;
   logic [11:0]    prev_ff, prev_in;
   logic [7:0]     fc_ff, fc_in;
   logic [SLW-1:0] level_ff, level_in;
   logic [15:0]    bytes_ff, bytes_in;
   logic [2:0]     phase_ff, phase_in;
   logic [15:0]    limit_ff, limit_in;
   logic [11:0]    code_ff, code_in;
   logic [11:0]    walk_ff, walk_in;
   logic [CLW-1:0] steps_ff, steps_in;
   logic [7:0]     last_ff, last_in;
   logic           oob_ff, oob_in;
   logic [7:0]     res_byte_ff, res_byte_in;
   logic [2:0]     res_st_ff, res_st_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic [2:0]     rsp_user_ff, rsp_user_in;

   lzwvd_pkg::dict_cmd_type  dict_cmd;
   lzwvd_pkg::stack_cmd_type stack_cmd;
   logic [11:0] dict_prefix;
   logic [7:0]  dict_suffix;
   logic [7:0]  stack_rd;

   logic [11:0] code_mask, code_cur, grow_lim, pfx_eff;
   logic [7:0]  sfx_eff;
   logic        stack_full;

   lzwvd_dict #(.TABLE_DEPTH(TABLE_DEPTH)) u_dict (
      .clock     (clock),
      .cmd       (dict_cmd),
      .rd_prefix (dict_prefix),
      .rd_suffix (dict_suffix)
   );

   lzwvd_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .cmd     (stack_cmd),
      .rd_data (stack_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign code_mask  = (12'd1 << width_ff) - 12'd1;
   assign code_cur   = buf_ff[11:0] & code_mask;
   assign grow_lim   = (12'd1 << width_ff) - 12'd2;
   assign stack_full = (level_ff >= SLW'(STACK_DEPTH));
   assign pfx_eff    = oob_ff ? 12'd0 : dict_prefix;
   assign sfx_eff    = oob_ff ? 8'd0 : dict_suffix;

   always_comb begin
      state_in     = state_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      width_in     = width_ff;
      nfc_in       = nfc_ff;
      prev_in      = prev_ff;
      fc_in        = fc_ff;
      level_in     = level_ff;
      bytes_in     = bytes_ff;
      phase_in     = phase_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      code_in      = code_ff;
      walk_in      = walk_ff;
      steps_in     = steps_ff;
      last_in      = last_ff;
      oob_in       = oob_ff;
      res_byte_in  = res_byte_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      dict_cmd     = '0;
      stack_cmd    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_byte_in = 8'd0;
               state_in    = S_EMIT;
               priority if (req_tuser == lzwvd_pkg::OP_FEED) begin
                  if (cnt_ff <= lzwvd_pkg::FEED_MAX_CNT) begin
                     buf_in    = buf_ff | ({24'd0, req_tdata} << cnt_ff);
                     cnt_in    = cnt_ff + 6'd8;
                     res_st_in = lzwvd_pkg::ST_TAKEN;
                  end else begin
                     res_st_in = lzwvd_pkg::ST_REFUSED;
                  end
               end else if (req_tuser == lzwvd_pkg::OP_START) begin
                  buf_in    = '0;
                  cnt_in    = '0;
                  width_in  = lzwvd_pkg::WIDTH_MIN;
                  nfc_in    = lzwvd_pkg::FREE_START;
                  prev_in   = '0;
                  fc_in     = '0;
                  level_in  = '0;
                  bytes_in  = '0;
                  phase_in  = lzwvd_pkg::PH_FIRST;
                  res_st_in = lzwvd_pkg::ST_TAKEN;
               end else if (req_tuser == lzwvd_pkg::OP_PULL) begin
                  priority if (phase_ff == lzwvd_pkg::PH_ENDED ||
                               phase_ff > lzwvd_pkg::PH_ERROR) begin
                     res_st_in = lzwvd_pkg::ST_ENDED;
                  end else if (phase_ff == lzwvd_pkg::PH_ERROR) begin
                     res_st_in = lzwvd_pkg::ST_ERROR;
                  end else if (bytes_ff >= limit_ff) begin
                     phase_in  = lzwvd_pkg::PH_ENDED;
                     res_st_in = lzwvd_pkg::ST_ENDED;
                  end else if (level_ff != '0) begin
                     // pop: memory data arrives next cycle
                     stack_cmd.raddr = SIW'(level_ff - SLW'(1));
                     level_in        = level_ff - SLW'(1);
                     bytes_in        = bytes_ff + 16'd1;
                     state_in        = S_POPDT;
                  end else begin
                     state_in = S_LOOP;
                  end
               end else begin
                  res_st_in = lzwvd_pkg::ST_REFUSED;
               end
            end
         end

         S_LOOP: begin
            if (cnt_ff < {2'd0, width_ff}) begin
               res_byte_in = 8'd0;
               res_st_in   = lzwvd_pkg::ST_NEED;
               state_in    = S_EMIT;
            end else begin
               buf_in = buf_ff >> width_ff;
               cnt_in = cnt_ff - {2'd0, width_ff};
               priority if (phase_ff == lzwvd_pkg::PH_FIRST) begin
                  prev_in  = code_cur;
                  fc_in    = code_cur[7:0];
                  phase_in = lzwvd_pkg::PH_RUN;
               end else if (phase_ff == lzwvd_pkg::PH_LITERAL) begin
                  prev_in     = code_cur;
                  fc_in       = code_cur[7:0];
                  phase_in    = lzwvd_pkg::PH_RUN;
                  bytes_in    = bytes_ff + 16'd1;
                  res_byte_in = code_cur[7:0];
                  res_st_in   = lzwvd_pkg::ST_BYTE;
                  state_in    = S_EMIT;
               end else if (code_cur == lzwvd_pkg::CODE_EOI) begin
                  phase_in    = lzwvd_pkg::PH_ENDED;
                  res_byte_in = 8'd0;
                  res_st_in   = lzwvd_pkg::ST_ENDED;
                  state_in    = S_EMIT;
               end else if (code_cur == lzwvd_pkg::CODE_CLEAR) begin
                  nfc_in   = lzwvd_pkg::FREE_RESTART;
                  width_in = lzwvd_pkg::WIDTH_MIN;
                  phase_in = lzwvd_pkg::PH_LITERAL;
               end else begin
                  code_in  = code_cur;
                  steps_in = '0;
                  state_in = S_WALK;
                  if (code_cur >= nfc_ff) begin
                     // unknown code: string of previous plus its first byte
                     stack_cmd.we    = 1'b1;
                     stack_cmd.waddr = '0;
                     stack_cmd.wdata = fc_ff;
                     level_in        = SLW'(1);
                     walk_in         = prev_ff;
                  end else begin
                     level_in = '0;
                     walk_in  = code_cur;
                  end
               end
            end
         end

         S_WALK: begin
            if (walk_ff > lzwvd_pkg::LITERAL_MAX) begin
               dict_cmd.raddr = walk_ff;
               oob_in         = ({1'b0, walk_ff} >= 13'(TABLE_DEPTH));
               state_in       = S_WALKDT;
            end else if (stack_full) begin
               level_in    = '0;
               phase_in    = lzwvd_pkg::PH_ERROR;
               res_byte_in = 8'd0;
               res_st_in   = lzwvd_pkg::ST_ERROR;
               state_in    = S_EMIT;
            end else begin
               stack_cmd.we    = 1'b1;
               stack_cmd.waddr = SIW'(level_ff);
               stack_cmd.wdata = walk_ff[7:0];
               level_in        = level_ff + SLW'(1);
               last_in         = walk_ff[7:0];
               state_in        = S_FINISH;
            end
         end

         S_WALKDT: begin
            if (stack_full || steps_ff >= CLW'(CHAIN_LIMIT)) begin
               level_in    = '0;
               phase_in    = lzwvd_pkg::PH_ERROR;
               res_byte_in = 8'd0;
               res_st_in   = lzwvd_pkg::ST_ERROR;
               state_in    = S_EMIT;
            end else begin
               stack_cmd.we    = 1'b1;
               stack_cmd.waddr = SIW'(level_ff);
               stack_cmd.wdata = sfx_eff;
               level_in        = level_ff + SLW'(1);
               walk_in         = pfx_eff;
               steps_in        = steps_ff + CLW'(1);
               state_in        = S_WALK;
            end
         end

         S_FINISH: begin
            // top of stack is the last byte pushed: emit it without a read
            fc_in = last_ff;
            if (nfc_ff > grow_lim && width_ff != lzwvd_pkg::WIDTH_MAX) begin
               width_in = width_ff + 4'd1;
            end
            if ({1'b0, nfc_ff} < 13'(TABLE_DEPTH)) begin
               dict_cmd.we      = 1'b1;
               dict_cmd.waddr   = nfc_ff;
               dict_cmd.wprefix = prev_ff;
               dict_cmd.wsuffix = last_ff;
            end
            if (nfc_ff < lzwvd_pkg::FREE_MAX) begin
               nfc_in = nfc_ff + 12'd1;
            end
            prev_in     = code_ff;
            level_in    = level_ff - SLW'(1);
            bytes_in    = bytes_ff + 16'd1;
            res_byte_in = last_ff;
            res_st_in   = lzwvd_pkg::ST_BYTE;
            state_in    = S_EMIT;
         end

         S_POPDT: begin
            res_byte_in = stack_rd;
            res_st_in   = lzwvd_pkg::ST_BYTE;
            state_in    = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_byte_ff;
               rsp_user_in  = res_st_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         width_ff     <= lzwvd_pkg::WIDTH_MIN;
         nfc_ff       <= lzwvd_pkg::FREE_START;
         prev_ff      <= '0;
         fc_ff        <= '0;
         level_ff     <= '0;
         bytes_ff     <= '0;
         phase_ff     <= lzwvd_pkg::PH_FIRST;
         limit_ff     <= lzwvd_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         nfc_ff       <= nfc_in;
         prev_ff      <= prev_in;
         fc_ff        <= fc_in;
         level_ff     <= level_in;
         bytes_ff     <= bytes_in;
         phase_ff     <= phase_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      walk_ff     <= walk_in;
      steps_ff    <= steps_in;
      last_ff     <= last_in;
      oob_ff      <= oob_in;
      res_byte_ff <= res_byte_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end
endmodule
`default_nettype wire

// ----- sv/lzwvd_checker.sv -----
// Port-level checker for the LZW variable width decoder, bound to the top.
// Depends on lzw_variable_width_decoder_macros.svh and lzwvd_pkg.
`default_nettype none
`include "lzw_variable_width_decoder_macros.svh"
module lzwvd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);
   `LZWVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "rsp beat dropped")
   `LZWVD_ASSERT_NOW(a_status_range, clock, reset, rsp_tvalid,
      rsp_tuser <= lzwvd_pkg::ST_ERROR, "bad status")
   `LZWVD_ASSERT_NOW(a_zero_byte, clock, reset, rsp_tvalid && rsp_tuser != lzwvd_pkg::ST_BYTE,
      rsp_tdata == 8'd0, "nonzero byte")
   `LZWVD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready,
      "second beat taken")
endmodule

bind lzw_variable_width_decoder lzwvd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
